// ===== rtl/gda_pkg.sv =====
// Shared types and constants for the Gregorian date add-days block.
// Used by the sequencer, the leap-year unit, the datapath and the top level.
// Depends on nothing.
`default_nettype none
package gda_pkg;

  // Field widths.
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int ADD_W   = 12;
  // Working day count holds the old day plus the largest add (31 + 4095).
  localparam int WDAY_W  = 13;

  // Step counter of the microprogram.
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  // Datapath operations.
  typedef logic [2:0] op_t;
  localparam op_t OP_NOP    = 3'd0;
  localparam op_t OP_LOAD   = 3'd1;
  localparam op_t OP_MSTEP  = 3'd2;
  localparam op_t OP_SETCHK = 3'd3;
  localparam op_t OP_COMMIT = 3'd4;

  // Branch conditions.
  typedef logic [2:0] cond_t;
  localparam cond_t C_ALWAYS  = 3'd0;
  localparam cond_t C_START   = 3'd1;
  localparam cond_t C_SET     = 3'd2;
  localparam cond_t C_MLOOP   = 3'd3;
  localparam cond_t C_OUTFREE = 3'd4;

  // One control word: operation, condition, taken and not-taken targets.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ctrl_word_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic kind_add;  // captured item is an add
    logic fits;      // working day fits in the working month
    logic wrap;      // month step would roll into a new year
    logic ovf;       // year roll would pass the year limit
  } status_t;

  // Program addresses.
  localparam step_t S_IDLE   = 3'd0;
  localparam step_t S_LOAD   = 3'd1;
  localparam step_t S_LEAP1  = 3'd2;
  localparam step_t S_LEAP2  = 3'd3;
  localparam step_t S_KIND   = 3'd4;
  localparam step_t S_MONTH  = 3'd5;
  localparam step_t S_CHECK  = 3'd6;
  localparam step_t S_COMMIT = 3'd7;

  // Calendar constants.
  localparam logic [DAY_W-1:0]   MLEN_LEAP_FEB = 5'd29;
  localparam logic [DAY_W-1:0]   MLEN_FEB      = 5'd28;
  localparam logic [DAY_W-1:0]   MLEN_SHORT    = 5'd30;
  localparam logic [DAY_W-1:0]   MLEN_LONG     = 5'd31;
  localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_SET_MAX  = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEAR_LIMIT    = 14'd16383;
  localparam logic [YEAR_W-1:0]  YEAR_CENT     = 14'd100;

  // Reset date.
  localparam logic [DAY_W-1:0]   RST_DAY   = 5'd1;
  localparam logic [MONTH_W-1:0] RST_MONTH = 4'd1;
  localparam logic [YEAR_W-1:0]  RST_YEAR  = 14'd1970;

  // Division by 100 as (y * 5243) >> 19, exact for every 14-bit year.
  localparam int              RECIP_W     = 13;
  localparam logic [12:0]     RECIP_100   = 13'd5243;
  localparam int              RECIP_SHIFT = 19;
  localparam int              QUOT_W      = 8;

endpackage
`default_nettype wire

// ===== rtl/gregorian_date_add_days.sv =====
// A set transfer runs through the load, leap-wait, kind, check and commit steps once accepted;
// an add walks one month per cycle in the month step, going back to the leap waits at each
// year crossed, and then commits. One item is handled at a time: the next is accepted in the
// idle step after its commit, which waits until the output register can take the result.
// Reset (synchronous, active high) loads 1 January 1970, clears the output valid and idles the
// sequencer; the next cycle the block accepts input.
`default_nettype none
module gregorian_date_add_days (
  input  wire         clk,
  input  wire         rst,
  // Input stream.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: new_day[4:0], new_month[8:5], new_year[22:9], days_to_add[34:23],
  // zero fill [39:35].
  input  wire  [39:0] s_axis_tdata,
  // tuser: kind (0 = set date, 1 = add days).
  input  wire         s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata from bit 0: cur_day[4:0], cur_month[8:5], cur_year[22:9], zero fill [23].
  output logic [23:0] m_axis_tdata,
  // tuser: error.
  output logic        m_axis_tuser
);
  import gda_pkg::*;

  logic               in_fire;
  logic               out_free;
  logic               idle;
  op_t                op;
  status_t            stat;
  logic [DAY_W-1:0]   res_day;
  logic [MONTH_W-1:0] res_month;
  logic [YEAR_W-1:0]  res_year;
  logic               res_err;

  // The sequencer takes a new item only from its idle step, so an input
  // transfer always starts a fresh program run.
  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // The output register can take a result when it is empty or is being
  // drained in this cycle; a waiting result holds back the next commit, not the next input.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  gda_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .out_free (out_free),
    .stat     (stat),
    .op       (op),
    .idle     (idle)
  );

  gda_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .capture     (in_fire),
    .kind        (s_axis_tuser),
    .new_day     (s_axis_tdata[4:0]),
    .new_month   (s_axis_tdata[8:5]),
    .new_year    (s_axis_tdata[22:9]),
    .days_to_add (s_axis_tdata[34:23]),
    .op          (op),
    .stat        (stat),
    .cur_day     (res_day),
    .cur_month   (res_month),
    .cur_year    (res_year),
    .error       (res_err)
  );

  // Output register. The commit step of the program loads it in the same
  // cycle that the held date is updated.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (op == OP_COMMIT) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_COMMIT) begin
      m_axis_tdata <= {1'b0, res_year, res_month, res_day};
      m_axis_tuser <= res_err;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gda_seq.sv =====
// Microprogram sequencer: control store, step counter and branch logic.
// Depends on gda_pkg.
`default_nettype none
module gda_seq (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_fire,
  input  wire              out_free,
  input  gda_pkg::status_t stat,
  output gda_pkg::op_t     op,
  output logic             idle
);
  import gda_pkg::*;

  localparam int STEPS = 1 << STEP_W;

  // The whole program. Step 5 walks one month per cycle and branches back to
  // the leap wait whenever a year boundary is crossed.
  localparam ctrl_word_t ROM [STEPS] = '{
    '{OP_NOP,    C_START,   S_LOAD,  S_IDLE},
    '{OP_LOAD,   C_ALWAYS,  S_LEAP1, S_LEAP1},
    '{OP_NOP,    C_ALWAYS,  S_LEAP2, S_LEAP2},
    '{OP_NOP,    C_ALWAYS,  S_KIND,  S_KIND},
    '{OP_NOP,    C_SET,     S_CHECK, S_MONTH},
    '{OP_MSTEP,  C_MLOOP,   S_COMMIT, S_LEAP1},
    '{OP_SETCHK, C_ALWAYS,  S_COMMIT, S_COMMIT},
    '{OP_COMMIT, C_OUTFREE, S_IDLE,  S_COMMIT}
  };

  step_t      upc;
  step_t      upc_next;
  ctrl_word_t cw;

  assign cw   = ROM[upc];
  assign idle = (upc == S_IDLE);

  // A commit waits until the output register can take the result.
  assign op = (cw.op == OP_COMMIT && !out_free) ? OP_NOP : cw.op;

  always_comb begin
    case (cw.cond)
      C_ALWAYS:  upc_next = cw.tgt_t;
      C_START:   upc_next = in_fire ? cw.tgt_t : cw.tgt_f;
      C_SET:     upc_next = stat.kind_add ? cw.tgt_f : cw.tgt_t;
      C_MLOOP: begin
        if (stat.fits || stat.ovf) begin
          upc_next = cw.tgt_t;
        end else if (stat.wrap) begin
          upc_next = cw.tgt_f;
        end else begin
          upc_next = upc;
        end
      end
      C_OUTFREE: upc_next = out_free ? cw.tgt_t : cw.tgt_f;
      default:   upc_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gda_leap.sv =====
// Two-stage leap-year unit for a 14-bit year.
// Depends on gda_pkg.
`default_nettype none
module gda_leap (
  input  wire                             clk,
  input  wire [gda_pkg::YEAR_W-1:0]       year,
  output logic                            leap
);
  import gda_pkg::*;

  localparam int PROD_W = YEAR_W + RECIP_W;

  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [YEAR_W-1:0] year1;
  logic [YEAR_W:0]   rem;

  assign prod = PROD_W'(year) * PROD_W'(RECIP_100);

  // Stage one: quotient by 100.
  always_ff @(posedge clk) begin
    quot  <= prod[RECIP_SHIFT +: QUOT_W];
    year1 <= year;
  end

  // Stage two: remainder by 100, then the Gregorian rule. A year is a
  // multiple of 400 when it is a multiple of 100 with a quotient divisible
  // by four.
  assign rem = {1'b0, year1} - ((YEAR_W+1)'(quot) * (YEAR_W+1)'(YEAR_CENT));

  always_ff @(posedge clk) begin
    leap <= (year1[1:0] == 2'd0 && rem != '0) || (rem == '0 && quot[1:0] == 2'd0);
  end

endmodule
`default_nettype wire

// ===== rtl/gda_dpath.sv =====
// Datapath: captured item, working date, month walker, set check and the
// held date. Depends on gda_pkg and gda_leap.
`default_nettype none
module gda_dpath (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          capture,
  input  wire                          kind,
  input  wire [gda_pkg::DAY_W-1:0]     new_day,
  input  wire [gda_pkg::MONTH_W-1:0]   new_month,
  input  wire [gda_pkg::YEAR_W-1:0]    new_year,
  input  wire [gda_pkg::ADD_W-1:0]     days_to_add,
  input  gda_pkg::op_t                 op,
  output gda_pkg::status_t             stat,
  output logic [gda_pkg::DAY_W-1:0]    cur_day,
  output logic [gda_pkg::MONTH_W-1:0]  cur_month,
  output logic [gda_pkg::YEAR_W-1:0]   cur_year,
  output logic                         error
);
  import gda_pkg::*;

  logic                kind_q;
  logic [DAY_W-1:0]    nd_q;
  logic [MONTH_W-1:0]  nm_q;
  logic [YEAR_W-1:0]   ny_q;
  logic [ADD_W-1:0]    add_q;

  logic [WDAY_W-1:0]   d;
  logic [MONTH_W-1:0]  m;
  logic [YEAR_W-1:0]   y;
  logic                err;

  logic [DAY_W-1:0]    day_reg;
  logic [MONTH_W-1:0]  month_reg;
  logic [YEAR_W-1:0]   year_reg;

  logic                leap;
  logic [DAY_W-1:0]    mlen;
  logic                set_ok;

  gda_leap u_leap (
    .clk  (clk),
    .year (y),
    .leap (leap)
  );

  always_comb begin
    if (m == MONTH_FEB) begin
      mlen = leap ? MLEN_LEAP_FEB : MLEN_FEB;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      mlen = MLEN_SHORT;
    end else begin
      mlen = MLEN_LONG;
    end
  end

  assign stat.kind_add = kind_q;
  assign stat.fits     = (d <= WDAY_W'(mlen));
  assign stat.wrap     = !stat.fits && (m == MONTH_DEC);
  assign stat.ovf      = stat.wrap && (y == YEAR_LIMIT);

  // The day is checked against the length of the new month in the new year.
  assign set_ok = (m >= MONTH_JAN) && (m <= MONTH_DEC) && (y != '0) &&
                  (y <= YEAR_SET_MAX) && (d != '0) && stat.fits;

  always_ff @(posedge clk) begin
    if (capture) begin
      kind_q <= kind;
      nd_q   <= new_day;
      nm_q   <= new_month;
      ny_q   <= new_year;
      add_q  <= days_to_add;
    end
    case (op)
      OP_LOAD: begin
        if (kind_q) begin
          d <= WDAY_W'(day_reg) + WDAY_W'(add_q);
          m <= month_reg;
          y <= year_reg;
        end else begin
          d <= WDAY_W'(nd_q);
          m <= nm_q;
          y <= ny_q;
        end
      end
      OP_MSTEP: begin
        if (!stat.fits && !stat.ovf) begin
          d <= d - WDAY_W'(mlen);
          if (stat.wrap) begin
            m <= MONTH_JAN;
            y <= y + YEAR_W'(1);
          end else begin
            m <= m + MONTH_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err       <= 1'b0;
      day_reg   <= RST_DAY;
      month_reg <= RST_MONTH;
      year_reg  <= RST_YEAR;
    end else begin
      case (op)
        OP_LOAD:   err <= 1'b0;
        OP_MSTEP: begin
          if (stat.ovf) begin
            err <= 1'b1;
          end
        end
        OP_SETCHK: err <= !set_ok;
        OP_COMMIT: begin
          if (!err) begin
            day_reg   <= d[DAY_W-1:0];
            month_reg <= m;
            year_reg  <= y;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cur_day   = err ? day_reg : d[DAY_W-1:0];
  assign cur_month = err ? month_reg : m;
  assign cur_year  = err ? year_reg : y;
  assign error     = err;

`ifndef NO_ASSERTIONS
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    month_reg >= MONTH_JAN && month_reg <= MONTH_DEC)
    else $error("held month out of range");

  a_day_nonzero: assert property (@(posedge clk) disable iff (rst)
    day_reg != '0)
    else $error("held day is zero");

  a_err_holds: assert property (@(posedge clk) disable iff (rst)
    op == OP_COMMIT && err |=> $stable(day_reg) && $stable(month_reg) && $stable(year_reg))
    else $error("rejected item changed the held date");
`endif

endmodule
`default_nettype wire
